FILE: rtl/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg: shared types, constants and microcode for the sample mixer
// Holds the control word layout, the step program and the register indexes.
// ----------------------------------------------------------------------------
package rvm_pkg;

   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_FRAC = 3'd1;
   localparam logic [STEP_W-1:0] STEP_BLEND    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_LEFT = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ACC_LEFT = 3'd4;
   localparam logic [STEP_W-1:0] STEP_FINISH   = 3'd5;

   localparam logic [2:0] CSR_MIX_MODE     = 3'd0;
   localparam logic [2:0] CSR_INTERPOLATE  = 3'd1;
   localparam logic [2:0] CSR_POS_STEP     = 3'd2;
   localparam logic [2:0] CSR_START_POS    = 3'd3;
   localparam logic [2:0] CSR_LEFT_START   = 3'd4;
   localparam logic [2:0] CSR_RIGHT_START  = 3'd5;
   localparam logic [2:0] CSR_LEFT_RAMP    = 3'd6;
   localparam logic [2:0] CSR_RIGHT_RAMP   = 3'd7;

   localparam logic [1:0] MODE_MONO     = 2'd0;
   localparam logic [1:0] MODE_STEREO   = 2'd1;
   localparam logic [1:0] MODE_SURROUND = 2'd2;

   typedef enum logic [1:0] {
      MUL_NONE   = 2'd0,
      MUL_INTERP = 2'd1,
      MUL_LEFT   = 2'd2,
      MUL_RIGHT  = 2'd3
   } mul_src_type;

   typedef enum logic [1:0] {
      COND_NONE     = 2'd0,
      COND_ITEM     = 2'd1,
      COND_OUT_FREE = 2'd2
   } cond_type;

   // One control word per step
   typedef struct packed {
      logic              take;       // accept an item in this step
      mul_src_type       mul_src;    // multiplier operands, product registered
      logic              blend;      // finish the interpolated sample
      logic              acc_left;   // add scaled product to left accumulator
      logic              finish;     // right accumulator, position, result
      cond_type          cond;
      logic [STEP_W-1:0] next_step;
      logic [STEP_W-1:0] alt_step;
   } ctl_word_type;

   typedef struct packed {
      logic item;       // an item is offered
      logic interp;     // interpolation enabled
      logic out_free;   // result register can take a new result
   } seq_status_type;

   function automatic ctl_word_type ucode(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '{take: 1'b0, mul_src: MUL_NONE, blend: 1'b0, acc_left: 1'b0,
            finish: 1'b0, cond: COND_NONE, next_step: STEP_IDLE, alt_step: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.take      = 1'b1;
            w.cond      = COND_ITEM;
            w.next_step = STEP_MUL_FRAC;
            w.alt_step  = STEP_MUL_LEFT;
         end
         STEP_MUL_FRAC: begin
            w.mul_src   = MUL_INTERP;
            w.next_step = STEP_BLEND;
         end
         STEP_BLEND: begin
            w.blend     = 1'b1;
            w.next_step = STEP_MUL_LEFT;
         end
         STEP_MUL_LEFT: begin
            w.mul_src   = MUL_LEFT;
            w.next_step = STEP_ACC_LEFT;
         end
         STEP_ACC_LEFT: begin
            w.acc_left  = 1'b1;
            w.mul_src   = MUL_RIGHT;
            w.next_step = STEP_FINISH;
         end
         STEP_FINISH: begin
            w.finish    = 1'b1;
            w.cond      = COND_OUT_FREE;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/ramped_volume_sample_mixer.sv
// ----------------------------------------------------------------------------
// ramped_volume_sample_mixer: one mixed output frame per item
// Ramps the volumes, optionally interpolates the source sample, scales it, adds
// it to the left accumulator, updates the right one by mode and advances the position.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame: two source samples, the two accumulator words and
//   a restart flag (req_tuser). rsp_* returns the updated accumulators and next fetch
//   index. The user writes csr_* only while idle, one setting per cycle; not enforced.
// Timing:
//   A microcoded sequencer drives one shared 33x17 multiplier. Without
//   interpolation an item runs through the accept, left product, right product
//   and finish steps; with it, a fraction product step and a blend step follow
//   accept. The result is valid in the cycle after the finish step; the next
//   item can be accepted in that same cycle, and not while one is in work.
// Reset:
//   Settings go to their defaults (stereo, no interpolation, step 1.0),
//   position and volumes to zero, the output register empties.
// Stall:
//   A result waits in the output register; the next item is still accepted
//   and worked on, and holds in its finish step until the register frees.
// ----------------------------------------------------------------------------
module ramped_volume_sample_mixer #(
   parameter int VOLUME_SHIFT = 9,
   parameter int INTERP_SHIFT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // sample_here, sample_after, acc_left_in, acc_right_in
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // acc_left_out, acc_right_out, fetch_index
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic signed [32:0] VOL_BIAS =
      33'((64'd1 << VOLUME_SHIFT) - 64'd1);

   // settings
   logic [1:0]  mix_mode_ff;
   logic        interp_ff;
   logic [63:0] pos_step_ff;
   logic [63:0] start_pos_ff;
   logic [31:0] lstart_ff;
   logic [31:0] rstart_ff;
   logic [31:0] lramp_ff;
   logic [31:0] rramp_ff;

   // running state
   logic [63:0] pos_ff;
   logic [31:0] lvol_ff;
   logic [31:0] rvol_ff;

   // item under work
   logic [15:0] here_ff;
   logic [15:0] after_ff;
   logic [15:0] smp_ff;
   logic [31:0] accl_ff;
   logic [31:0] accr_ff;
   logic signed [49:0] prod_ff;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_data_ff;

   rvm_pkg::ctl_word_type   ctl;
   rvm_pkg::seq_status_type status;

   logic               accept;
   logic               out_free;
   logic               fin_fire;
   logic               stereo;
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [16:0] diff;
   logic [31:0]        prod_lo;
   logic signed [32:0] bias_sum;
   logic signed [32:0] quo;
   logic [31:0]        scaled;
   logic [31:0]        accr_new;
   logic [63:0]        pos_next;

   assign req_tready = ctl.take & ~reset;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign fin_fire   = ctl.finish & out_free;
   assign stereo     = (mix_mode_ff != rvm_pkg::MODE_MONO) &&
                       (mix_mode_ff != rvm_pkg::MODE_SURROUND);

   assign status = '{item: req_tvalid, interp: interp_ff, out_free: out_free};

   rvm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // shared multiplier operands
   assign diff = $signed({after_ff[15], after_ff}) - $signed({here_ff[15], here_ff});

   always_comb begin
      case (ctl.mul_src)
         rvm_pkg::MUL_INTERP: begin
            mul_a = $signed(33'(pos_ff[31:INTERP_SHIFT]));
            mul_b = diff;
         end
         rvm_pkg::MUL_LEFT: begin
            mul_a = $signed({lvol_ff[31], lvol_ff});
            mul_b = $signed({smp_ff[15], smp_ff});
         end
         rvm_pkg::MUL_RIGHT: begin
            // surround reuses the left volume and subtracts
            mul_a = stereo ? $signed({rvol_ff[31], rvol_ff}) : $signed({lvol_ff[31], lvol_ff});
            mul_b = $signed({smp_ff[15], smp_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // keep 32 product bits, divide by 2^VOLUME_SHIFT toward zero
   assign prod_lo  = prod_ff[31:0];
   assign bias_sum = $signed({prod_lo[31], prod_lo}) +
                     (prod_lo[31] ? VOL_BIAS : 33'sd0);
   assign quo      = bias_sum >>> VOLUME_SHIFT;
   assign scaled   = quo[31:0];

   assign pos_next = pos_ff + pos_step_ff;

   always_comb begin
      case (mix_mode_ff)
         rvm_pkg::MODE_MONO:     accr_new = accr_ff;
         rvm_pkg::MODE_SURROUND: accr_new = accr_ff - scaled;
         default:                accr_new = accr_ff + scaled;
      endcase
   end

   // settings port
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_mode_ff  <= rvm_pkg::MODE_STEREO;
         interp_ff    <= 1'b0;
         pos_step_ff  <= 64'h0000_0001_0000_0000;
         start_pos_ff <= '0;
         lstart_ff    <= '0;
         rstart_ff    <= '0;
         lramp_ff     <= '0;
         rramp_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rvm_pkg::CSR_MIX_MODE:    mix_mode_ff  <= csr_wdata[1:0];
            rvm_pkg::CSR_INTERPOLATE: interp_ff    <= csr_wdata[0];
            rvm_pkg::CSR_POS_STEP:    pos_step_ff  <= csr_wdata;
            rvm_pkg::CSR_START_POS:   start_pos_ff <= csr_wdata;
            rvm_pkg::CSR_LEFT_START:  lstart_ff    <= csr_wdata[31:0];
            rvm_pkg::CSR_RIGHT_START: rstart_ff    <= csr_wdata[31:0];
            rvm_pkg::CSR_LEFT_RAMP:   lramp_ff     <= csr_wdata[31:0];
            rvm_pkg::CSR_RIGHT_RAMP:  rramp_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // position and volumes: reload on restart, ramp on accept, advance at finish
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         lvol_ff <= '0;
         rvol_ff <= '0;
      end else if (accept) begin
         if (req_tuser) begin
            pos_ff <= start_pos_ff;
         end
         lvol_ff <= (req_tuser ? lstart_ff : lvol_ff) + lramp_ff;
         if (stereo) begin
            rvol_ff <= (req_tuser ? rstart_ff : rvol_ff) + rramp_ff;
         end else if (req_tuser) begin
            rvol_ff <= rstart_ff;
         end
      end else if (fin_fire) begin
         pos_ff <= pos_next;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         here_ff  <= req_tdata[15:0];
         after_ff <= req_tdata[31:16];
         smp_ff   <= req_tdata[15:0];
         accl_ff  <= req_tdata[63:32];
         accr_ff  <= req_tdata[95:64];
      end else begin
         if (ctl.blend) begin
            smp_ff <= here_ff + prod_ff[INTERP_SHIFT+15:INTERP_SHIFT];
         end
         if (ctl.acc_left) begin
            accl_ff <= accl_ff + scaled;
         end
      end
      if (ctl.mul_src != rvm_pkg::MUL_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
      if (fin_fire) begin
         rsp_data_ff <= {pos_next[63:32], accr_new, accl_ff};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/rvm_sequencer.sv
// ----------------------------------------------------------------------------
// rvm_sequencer: step counter and microcode fetch
// Reads the control word of the current step and picks the next step.
// ----------------------------------------------------------------------------
module rvm_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  rvm_pkg::seq_status_type status,
   output rvm_pkg::ctl_word_type   ctl
);

   logic [rvm_pkg::STEP_W-1:0] step_ff;
   logic [rvm_pkg::STEP_W-1:0] step_in;

   assign ctl = rvm_pkg::ucode(step_ff);

   always_comb begin
      unique case (ctl.cond)
         rvm_pkg::COND_ITEM: begin
            if (!status.item) begin
               step_in = step_ff;
            end else if (status.interp) begin
               step_in = ctl.next_step;
            end else begin
               step_in = ctl.alt_step;
            end
         end
         rvm_pkg::COND_OUT_FREE: begin
            step_in = status.out_free ? ctl.next_step : step_ff;
         end
         default: begin
            step_in = ctl.next_step;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rvm_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
